@@ rtl/edge_list_csr_builder_defines.svh @@
// Assertion macros shared by the edge list to CSR builder.
`ifndef EDGE_LIST_CSR_BUILDER_DEFINES_SVH
`define EDGE_LIST_CSR_BUILDER_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define ECB_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define ECB_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define ECB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ecb_pkg.sv @@
// Types and constants shared by the edge list to CSR builder modules.
package ecb_pkg;

   localparam int KEY_W     = 10;
   localparam int KEY_COUNT = 1 << KEY_W;
   localparam int NODE_W    = 11;
   localparam int POS_W     = 13;

   typedef enum logic [1:0] {
      CMD_LOAD        = 2'd0,
      CMD_READ_EDGE   = 2'd1,
      CMD_READ_OFFSET = 2'd2,
      CMD_RESERVED    = 2'd3
   } ecb_cmd_type;

   typedef enum logic [1:0] {
      KIND_DONE   = 2'd0,
      KIND_EDGE   = 2'd1,
      KIND_OFFSET = 2'd2
   } ecb_kind_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [KEY_W-1:0] row_index;
      logic [KEY_W-1:0] column_index;
      logic             last_edge;
      logic [POS_W-1:0] position;
   } ecb_req_type;

   typedef struct packed {
      logic [1:0]       result_kind;
      logic [KEY_W-1:0] out_row;
      logic [KEY_W-1:0] out_column;
      logic [POS_W-1:0] out_offset;
      logic             error_flag;
   } ecb_rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] row;
      logic [KEY_W-1:0] column;
   } ecb_edge_type;

   typedef struct packed {
      logic a_rd_en;
      logic a_wr_en;
      logic off_wr_en;
      logic done;
   } ecb_sort_ctl_type;

   typedef enum logic [2:0] {
      T_IDLE,
      T_SORT,
      T_BUILD_RSP,
      T_RD_EDGE,
      T_RD_OFF
   } ecb_top_state_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLR,
      S_CNT_RD,
      S_CNT_KEY,
      S_CNT_WR,
      S_PFX_RD,
      S_PFX_WR,
      S_SCT_RD,
      S_SCT_KEY,
      S_SCT_WR,
      S_DONE
   } ecb_sort_state_type;

endpackage

@@ rtl/ecb_sorter.sv @@
// Two pass radix sorter with a shared bucket adder that also writes the row offsets.
module ecb_sorter
   import ecb_pkg::*;
#(
   parameter int MAX_EDGES = 4096,
   parameter int MAX_NODES = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [$clog2(MAX_EDGES+1)-1:0]       edge_count,
   input  logic [NODE_W-1:0]                    node_limit,
   output logic [$clog2(MAX_EDGES)-1:0]         a_rd_addr,
   input  ecb_edge_type                         a_rd_data,
   output logic [$clog2(MAX_EDGES)-1:0]         a_wr_addr,
   output ecb_edge_type                         a_wr_data,
   output logic [$clog2(MAX_NODES+1)-1:0]       off_wr_addr,
   output logic [POS_W-1:0]                     off_wr_data,
   output ecb_sort_ctl_type                     ctl
);

   localparam int AW    = $clog2(MAX_EDGES);
   localparam int CNT_W = $clog2(MAX_EDGES+1);
   localparam int OAW   = $clog2(MAX_NODES+1);

   ecb_sort_state_type state_ff, state_in;
   logic               pass_ff, pass_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [KEY_W-1:0]   k_ff, k_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   ecb_edge_type       word_ff, word_in;
   logic [CNT_W-1:0]   sum_ff, sum_in;

   logic [CNT_W-1:0]   bkt_mem [KEY_COUNT];
   logic [CNT_W-1:0]   bkt_rd_ff;
   logic               bkt_we, bkt_re;
   logic [KEY_W-1:0]   bkt_waddr, bkt_raddr;
   logic [CNT_W-1:0]   bkt_wdata;

   ecb_edge_type       b_mem [MAX_EDGES];
   ecb_edge_type       b_rd_ff;
   logic               b_we, b_re;
   logic [AW-1:0]      b_waddr, b_raddr;

   ecb_edge_type       src_word;
   logic [KEY_W-1:0]   src_key;
   logic [CNT_W-1:0]   add_sum;

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bkt_mem[bkt_waddr] <= bkt_wdata;
      end
      if (bkt_re) begin
         bkt_rd_ff <= bkt_mem[bkt_raddr];
      end
      if (b_we) begin
         b_mem[b_waddr] <= word_ff;
      end
      if (b_re) begin
         b_rd_ff <= b_mem[b_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
      idx_ff  <= idx_in;
      k_ff    <= k_in;
      key_ff  <= key_in;
      word_ff <= word_in;
      sum_ff  <= sum_in;
   end

   // The first pass orders by column from the load buffer into the local buffer,
   // the second orders by row back again, so the result lands in the load buffer.
   assign src_word = pass_ff ? b_rd_ff : a_rd_data;
   assign src_key  = pass_ff ? src_word.row : src_word.column;
   assign add_sum  = bkt_rd_ff + ((state_ff == S_PFX_WR) ? sum_ff : CNT_W'(1));

   assign a_wr_data = word_ff;

   always_comb begin
      state_in    = state_ff;
      pass_in     = pass_ff;
      idx_in      = idx_ff;
      k_in        = k_ff;
      key_in      = key_ff;
      word_in     = word_ff;
      sum_in      = sum_ff;
      bkt_we      = 1'b0;
      bkt_re      = 1'b0;
      bkt_waddr   = k_ff;
      bkt_raddr   = k_ff;
      bkt_wdata   = '0;
      b_we        = 1'b0;
      b_re        = 1'b0;
      b_waddr     = AW'(bkt_rd_ff);
      b_raddr     = AW'(idx_ff);
      a_rd_addr   = AW'(idx_ff);
      a_wr_addr   = AW'(bkt_rd_ff);
      off_wr_addr = '0;
      off_wr_data = '0;
      ctl         = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               pass_in  = 1'b0;
               k_in     = '0;
               state_in = S_CLR;
            end
         end
         S_CLR: begin
            bkt_we = 1'b1;
            sum_in = '0;
            if (pass_ff && k_ff == '0) begin
               ctl.off_wr_en = 1'b1;
            end
            if (k_ff == KEY_W'(KEY_COUNT - 1)) begin
               k_in     = '0;
               idx_in   = '0;
               state_in = S_CNT_RD;
            end else begin
               k_in = k_ff + KEY_W'(1);
            end
         end
         S_CNT_RD: begin
            if (idx_ff == edge_count) begin
               state_in = S_PFX_RD;
            end else begin
               ctl.a_rd_en = !pass_ff;
               b_re        = pass_ff;
               state_in    = S_CNT_KEY;
            end
         end
         S_CNT_KEY: begin
            bkt_re    = 1'b1;
            bkt_raddr = src_key;
            key_in    = src_key;
            state_in  = S_CNT_WR;
         end
         S_CNT_WR: begin
            bkt_we    = 1'b1;
            bkt_waddr = key_ff;
            bkt_wdata = add_sum;
            idx_in    = idx_ff + CNT_W'(1);
            state_in  = S_CNT_RD;
         end
         S_PFX_RD: begin
            bkt_re   = 1'b1;
            state_in = S_PFX_WR;
         end
         S_PFX_WR: begin
            bkt_we    = 1'b1;
            bkt_wdata = sum_ff;
            sum_in    = add_sum;
            // Every offset entry is rewritten; those past the node count in use read zero.
            if (pass_ff && (32'(k_ff) < MAX_NODES)) begin
               ctl.off_wr_en = 1'b1;
               off_wr_addr   = OAW'({1'b0, k_ff} + NODE_W'(1));
               off_wr_data   = ({1'b0, k_ff} < node_limit) ? POS_W'(add_sum) : '0;
            end
            if (k_ff == KEY_W'(KEY_COUNT - 1)) begin
               idx_in   = '0;
               state_in = S_SCT_RD;
            end else begin
               k_in     = k_ff + KEY_W'(1);
               state_in = S_PFX_RD;
            end
         end
         S_SCT_RD: begin
            if (idx_ff == edge_count) begin
               if (pass_ff) begin
                  state_in = S_DONE;
               end else begin
                  pass_in  = 1'b1;
                  k_in     = '0;
                  state_in = S_CLR;
               end
            end else begin
               ctl.a_rd_en = !pass_ff;
               b_re        = pass_ff;
               state_in    = S_SCT_KEY;
            end
         end
         S_SCT_KEY: begin
            bkt_re    = 1'b1;
            bkt_raddr = src_key;
            key_in    = src_key;
            word_in   = src_word;
            state_in  = S_SCT_WR;
         end
         S_SCT_WR: begin
            ctl.a_wr_en = pass_ff;
            b_we        = !pass_ff;
            bkt_we      = 1'b1;
            bkt_waddr   = key_ff;
            bkt_wdata   = add_sum;
            idx_in      = idx_ff + CNT_W'(1);
            state_in    = S_SCT_RD;
         end
         S_DONE: begin
            ctl.done = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/edge_list_csr_builder.sv @@
// Top level of the edge list to CSR builder: channels, edge and offset stores, control.
// A load leaves the block idle and ready for the next request; a read registers the store's data
// and then, once the output register is free, its result. The last load runs the sort and build:
// per pass it clears all 1024 buckets, counts each edge (read, key, write), takes the prefix sum
// of the buckets and scatters each edge (read, key, write). No item is accepted meanwhile.
// Reset clears control state and the edge count and sets the node count to 1024; stores undefined.
`include "edge_list_csr_builder_defines.svh"

module edge_list_csr_builder
   import ecb_pkg::*;
#(
   parameter int MAX_EDGES = 4096,
   parameter int MAX_NODES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ecb_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ecb_rsp_type       rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [NODE_W-1:0] csr_wdata
);

   localparam int AW    = $clog2(MAX_EDGES);
   localparam int CNT_W = $clog2(MAX_EDGES+1);
   localparam int OAW   = $clog2(MAX_NODES+1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   ecb_top_state_type state_ff, state_in;
   logic [CNT_W-1:0]  edge_count_ff, edge_count_in;
   logic              dropped_ff, dropped_in;
   logic              err_ff, err_in;
   logic [NODE_W-1:0] node_count_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   ecb_rsp_type       rsp_data_ff, rsp_data_in;

   ecb_edge_type      a_mem [MAX_EDGES];
   ecb_edge_type      a_rd_ff;
   logic              a_we, a_re;
   logic [AW-1:0]     a_waddr, a_raddr;
   ecb_edge_type      a_wdata;

   logic [POS_W-1:0]  off_mem [MAX_NODES+1];
   logic [POS_W-1:0]  off_rd_ff;
   logic              off_re;

   logic              req_fire;
   logic              slot_free;
   logic              sort_start;
   logic [NODE_W-1:0] node_limit;
   ecb_sort_ctl_type  sort_ctl;
   logic [AW-1:0]     sort_rd_addr, sort_wr_addr;
   ecb_edge_type      sort_wr_data;
   logic [OAW-1:0]    off_wr_addr;
   logic [POS_W-1:0]  off_wr_data;

   // The configuration register is always writable; the user changes it only while idle.
   assign csr_ready = 1'b1;

   // Node count in use: the register saturated to MAX_NODES.
   assign node_limit = (32'(node_count_ff) > MAX_NODES) ? NODE_W'(MAX_NODES) : node_count_ff;

   assign req_ready = (state_ff == T_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The output register frees up in the same cycle its transaction completes.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   ecb_sorter #(
      .MAX_EDGES (MAX_EDGES),
      .MAX_NODES (MAX_NODES)
   ) u_sorter (
      .clock       (clock),
      .reset       (reset),
      .start       (sort_start),
      .edge_count  (edge_count_ff),
      .node_limit  (node_limit),
      .a_rd_addr   (sort_rd_addr),
      .a_rd_data   (a_rd_ff),
      .a_wr_addr   (sort_wr_addr),
      .a_wr_data   (sort_wr_data),
      .off_wr_addr (off_wr_addr),
      .off_wr_data (off_wr_data),
      .ctl         (sort_ctl)
   );

   // Edge store: written by loads and by the sort's second pass, read by edge
   // reads and by the sort's first pass. Offset store: written only by the build.
   always_ff @(posedge clock) begin
      if (a_we) begin
         a_mem[a_waddr] <= a_wdata;
      end
      if (a_re) begin
         a_rd_ff <= a_mem[a_raddr];
      end
      if (sort_ctl.off_wr_en) begin
         off_mem[off_wr_addr] <= off_wr_data;
      end
      if (off_re) begin
         off_rd_ff <= off_mem[OAW'(req_data.position)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         edge_count_ff <= '0;
         dropped_ff    <= 1'b0;
         node_count_ff <= NODE_W'(1024);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_count_ff <= edge_count_in;
         dropped_ff    <= dropped_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_wdata;
         end
      end
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      edge_count_in = edge_count_ff;
      dropped_in    = dropped_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      sort_start    = 1'b0;
      off_re        = 1'b0;
      a_we          = sort_ctl.a_wr_en;
      a_waddr       = sort_wr_addr;
      a_wdata       = sort_wr_data;
      a_re          = sort_ctl.a_rd_en;
      a_raddr       = sort_rd_addr;
      case (state_ff)
         T_IDLE: begin
            if (req_fire) begin
               case (req_data.command)
                  CMD_LOAD: begin
                     // A load is dropped when the store is full or its row is out of range.
                     if (edge_count_ff == CNT_W'(MAX_EDGES) ||
                         {1'b0, req_data.row_index} >= node_limit) begin
                        dropped_in = 1'b1;
                     end else begin
                        a_we          = 1'b1;
                        a_waddr       = AW'(edge_count_ff);
                        a_wdata       = '{row: req_data.row_index,
                                          column: req_data.column_index};
                        edge_count_in = edge_count_ff + CNT_W'(1);
                     end
                     if (req_data.last_edge) begin
                        sort_start = 1'b1;
                        state_in   = T_SORT;
                     end
                  end
                  CMD_READ_EDGE: begin
                     a_re     = 1'b1;
                     a_raddr  = AW'(req_data.position);
                     err_in   = CMP_W'(req_data.position) >= CMP_W'(edge_count_ff);
                     state_in = T_RD_EDGE;
                  end
                  CMD_READ_OFFSET: begin
                     off_re   = 1'b1;
                     err_in   = req_data.position > POS_W'(node_limit);
                     state_in = T_RD_OFF;
                  end
                  default: begin
                     // An unknown command is consumed without a result.
                     state_in = T_IDLE;
                  end
               endcase
            end
         end
         T_SORT: begin
            if (sort_ctl.done) begin
               state_in = T_BUILD_RSP;
            end
         end
         T_BUILD_RSP: begin
            // The build result reports the stored edge count and any drop since the last build.
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = '0;
               rsp_data_in.result_kind = KIND_DONE;
               rsp_data_in.out_offset  = POS_W'(edge_count_ff);
               rsp_data_in.error_flag  = dropped_ff;
               dropped_in              = 1'b0;
               state_in                = T_IDLE;
            end
         end
         T_RD_EDGE: begin
            // The read data stays put here because nothing else reads the edge store.
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = '0;
               rsp_data_in.result_kind = KIND_EDGE;
               rsp_data_in.error_flag  = err_ff;
               if (!err_ff) begin
                  rsp_data_in.out_row    = a_rd_ff.row;
                  rsp_data_in.out_column = a_rd_ff.column;
               end
               state_in = T_IDLE;
            end
         end
         T_RD_OFF: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = '0;
               rsp_data_in.result_kind = KIND_OFFSET;
               rsp_data_in.error_flag  = err_ff;
               if (!err_ff) begin
                  rsp_data_in.out_offset = off_rd_ff;
               end
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // The sorter reports completion only while the top level waits for it.
   `ECB_ASSERT_IMPL(a_done_in_sort, sort_ctl.done, state_ff == T_SORT, "sort done outside sort")
   // A load that carries the last mark always starts a sort and build.
   `ECB_ASSERT_NEXT(a_last_starts_sort, req_fire && req_data.command == CMD_LOAD && req_data.last_edge, state_ff == T_SORT, "last load did not start sort")
   // The edge count never runs past the store's capacity.
   `ECB_ASSERT_HOLDS(a_count_bound, edge_count_ff <= CNT_W'(MAX_EDGES), "edge count overflow")

endmodule
